/* design/dcf_pkg.sv */
// dcf_pkg: shared types, constants and helpers for the time code decoder
// no dependencies; imported by the decoder unit and its checker
package dcf_pkg;

    localparam int FRAME_SLOTS = 60;
    localparam int TIME_BITS   = 16;
    localparam int SLOT_BITS   = $clog2(FRAME_SLOTS);

    // pulse and spacing windows in ms
    localparam int SEC_MIN  = 900;
    localparam int SEC_MAX  = 1100;
    localparam int MARK_MIN = 1900;
    localparam int MARK_MAX = 2100;
    localparam int ZERO_MIN = 70;
    localparam int ZERO_MAX = 130;
    localparam int ONE_MIN  = 170;
    localparam int ONE_MAX  = 230;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_SECOND  = 3'd1,
        EV_MINUTE  = 3'd2,
        EV_ZERO    = 3'd3,
        EV_ONE     = 3'd4,
        EV_INVALID = 3'd5
    } event_t;

    typedef logic [TIME_BITS-1:0]   time_t;
    typedef logic [SLOT_BITS-1:0]   slot_idx_t;
    typedef logic [FRAME_SLOTS-1:0] slot_vec_t;

    // bcd weights 1,2,4,8,10,20,40,80
    function automatic logic [7:0] bcd_sum(input logic [7:0] bits);
        logic [7:0] tens;
        tens    = {4'd0, bits[7:4]};
        bcd_sum = {4'd0, bits[3:0]} + 8'((tens << 3) + (tens << 1));
    endfunction

endpackage

/* design/dcf77_time_code_decoder_unit.sv */
// dcf77_time_code_decoder_unit: edge classification, frame store and frame check
// depends on dcf_pkg
// a sample is held in the input register, its result in the result register;
// throughput: one sample per cycle while the result is not stalled; the decode is one
// pass of logic between the two registers, frame state is written with the result
// reset: frame store reads as all zero bits, latched time 0:00, day 1, month 1,
// weekday 6, year 17, frame_ok low
module dcf77_time_code_decoder_unit
    import dcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       signal_level,
    input  logic [15:0] time_ms,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] event_code,
    output logic       frame_done,
    output logic       frame_ok,
    output logic [5:0] minute_out,
    output logic [4:0] hour_out,
    output logic [4:0] day_out,
    output logic [2:0] weekday_out,
    output logic [3:0] month_out,
    output logic [7:0] year_out
);

    // input register
    logic      in_full_reg;
    logic      level_reg;
    time_t     now_reg;

    // result register
    logic      out_valid_reg;
    event_t    event_reg;
    logic      done_reg;

    // decoder state
    logic      prev_level_reg;
    time_t     last_fall_reg;
    slot_idx_t slot_idx_reg;
    slot_vec_t slot_one_reg;
    slot_vec_t slot_bad_reg;
    logic      good_reg;
    logic [5:0] minute_reg;
    logic [4:0] hour_reg;
    logic [4:0] day_reg;
    logic [2:0] weekday_reg;
    logic [3:0] month_reg;
    logic [7:0] year_reg;

    logic      advance;
    time_t     span;
    event_t    event_next;
    slot_vec_t slot_mask;
    slot_vec_t slot_one_next;
    slot_vec_t slot_bad_next;
    slot_idx_t slot_idx_next;

    logic [7:0] mi, hr, dy, wd, mo, yr;
    logic       frame_pass;

    assign advance  = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    assign span = now_reg - last_fall_reg;

    always_comb
    begin
        event_next = EV_NONE;
        if (level_reg != prev_level_reg)
        begin
            if (!level_reg)
            begin
                if (span >= time_t'(SEC_MIN) && span <= time_t'(SEC_MAX))
                    event_next = EV_SECOND;
                else if (span >= time_t'(MARK_MIN) && span <= time_t'(MARK_MAX))
                    event_next = EV_MINUTE;
                else
                    event_next = EV_INVALID;
            end
            else
            begin
                if (span >= time_t'(ZERO_MIN) && span <= time_t'(ZERO_MAX))
                    event_next = EV_ZERO;
                else if (span >= time_t'(ONE_MIN) && span <= time_t'(ONE_MAX))
                    event_next = EV_ONE;
                else
                    event_next = EV_INVALID;
            end
        end
    end

    assign slot_mask = slot_vec_t'(1) << slot_idx_reg;

    always_comb
    begin
        slot_one_next = slot_one_reg;
        slot_bad_next = slot_bad_reg;
        slot_idx_next = slot_idx_reg;
        case (event_next)
            EV_ONE:
            begin
                slot_one_next = slot_one_reg | slot_mask;
                slot_bad_next = slot_bad_reg & ~slot_mask;
            end
            EV_ZERO:
            begin
                slot_one_next = slot_one_reg & ~slot_mask;
                slot_bad_next = slot_bad_reg & ~slot_mask;
            end
            EV_INVALID:
            begin
                slot_one_next = slot_one_reg & ~slot_mask;
                slot_bad_next = slot_bad_reg | slot_mask;
            end
            EV_SECOND:
            begin
                // saturate at the last slot
                if (slot_idx_reg != slot_idx_t'(FRAME_SLOTS - 1))
                    slot_idx_next = slot_idx_reg + 1'b1;
            end
            EV_MINUTE:
                slot_idx_next = '0;
            default: ;
        endcase
    end

    // frame check, evaluated from the store as it stands at the minute mark
    assign mi = bcd_sum({1'b0, slot_one_reg[27:21]});
    assign hr = bcd_sum({2'b0, slot_one_reg[34:29]});
    assign dy = bcd_sum({2'b0, slot_one_reg[41:36]});
    assign wd = bcd_sum({5'b0, slot_one_reg[44:42]});
    assign mo = bcd_sum({3'b0, slot_one_reg[49:45]});
    assign yr = bcd_sum(slot_one_reg[57:50]);

    assign frame_pass = !(|slot_bad_reg[58:21])
                     && mo >= 8'd1 && mo <= 8'd12
                     && wd >= 8'd1 && wd <= 8'd7
                     && dy >= 8'd1 && dy <= 8'd31
                     && hr <= 8'd23
                     && mi <= 8'd59
                     && ((^slot_one_reg[27:21]) == slot_one_reg[28])
                     && ((^slot_one_reg[34:29]) == slot_one_reg[35])
                     && ((^slot_one_reg[57:36]) == slot_one_reg[58]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            level_reg      <= 1'b0;
            now_reg        <= '0;
            out_valid_reg  <= 1'b0;
            event_reg      <= EV_NONE;
            done_reg       <= 1'b0;
            prev_level_reg <= 1'b0;
            last_fall_reg  <= '0;
            slot_idx_reg   <= '0;
            slot_one_reg   <= '0;
            slot_bad_reg   <= '0;
            good_reg       <= 1'b0;
            minute_reg     <= 6'd0;
            hour_reg       <= 5'd0;
            day_reg        <= 5'd1;
            weekday_reg    <= 3'd6;
            month_reg      <= 4'd1;
            year_reg       <= 8'd17;
        end
        else
        begin
            if (in_ready)
            begin
                in_full_reg <= in_valid;
                if (in_valid)
                begin
                    level_reg <= signal_level;
                    now_reg   <= time_t'(time_ms);
                end
            end

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                event_reg      <= event_next;
                done_reg       <= (event_next == EV_MINUTE);
                prev_level_reg <= level_reg;
                if (level_reg != prev_level_reg && !level_reg)
                    last_fall_reg <= now_reg;
                slot_idx_reg <= slot_idx_next;
                slot_one_reg <= slot_one_next;
                slot_bad_reg <= slot_bad_next;
                if (event_next == EV_MINUTE)
                begin
                    good_reg <= frame_pass;
                    if (frame_pass)
                    begin
                        minute_reg  <= mi[5:0];
                        hour_reg    <= hr[4:0];
                        day_reg     <= dy[4:0];
                        weekday_reg <= wd[2:0];
                        month_reg   <= mo[3:0];
                        year_reg    <= yr;
                    end
                end
            end
        end
    end

    // latched time changes only when a result is loaded, so it rides with it
    assign out_valid   = out_valid_reg;
    assign event_code  = event_reg;
    assign frame_done  = done_reg;
    assign frame_ok    = good_reg;
    assign minute_out  = minute_reg;
    assign hour_out    = hour_reg;
    assign day_out     = day_reg;
    assign weekday_out = weekday_reg;
    assign month_out   = month_reg;
    assign year_out    = year_reg;

endmodule

/* design/dcf_chk.sv */
// dcf_chk: port level checks for the time code decoder, bound to the decoder unit
// depends on dcf_pkg and dcf77_time_code_decoder_unit
module dcf_chk
    import dcf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       signal_level,
    input logic [15:0] time_ms,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_code,
    input logic       frame_done,
    input logic       frame_ok,
    input logic [5:0] minute_out,
    input logic [4:0] hour_out,
    input logic [4:0] day_out,
    input logic [2:0] weekday_out,
    input logic [3:0] month_out,
    input logic [7:0] year_out
);

    // a waiting sample holds until its transfer
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(signal_level)
            && $stable(time_ms))
        else $error("input sample changed while waiting");

    // a closed frame is always reported as a minute mark
    a_done_is_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> event_code == EV_MINUTE)
        else $error("frame_done without minute mark");

    // a frame that passed carries an in-range time
    a_good_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_ok |-> minute_out <= 6'd59 && hour_out <= 5'd23
            && day_out >= 5'd1 && weekday_out >= 3'd1
            && month_out >= 4'd1 && month_out <= 4'd12)
        else $error("good frame with out of range time");

    // latched time moves only on a closed frame
    a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid && !frame_done
            |-> $stable(minute_out) && $stable(hour_out) && $stable(day_out)
                && $stable(month_out) && $stable(year_out))
        else $error("latched time changed without a minute mark");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code)
            && $stable(frame_done))
        else $error("result changed while stalled");

endmodule

bind dcf77_time_code_decoder_unit dcf_chk u_dcf_chk (.*);
